### hdl/dcr_pkg.sv
// shared constants, codes and types for the depth to color registration block
// no dependencies
package dcr_pkg;

    localparam int DEPTH_WIDTH_DEF  = 512;
    localparam int DEPTH_PIXELS_DEF = 217088;
    localparam int OUT_WIDTH_DEF    = 960;
    localparam int OUT_PIXELS_DEF   = 518400;

    localparam int ZW     = 16;   // depth sample width
    localparam int NUM_W  = 35;   // signed numerator of the column divide
    localparam int IDX_W  = 38;   // signed output index during patch placement
    localparam int Q_SHIFT = 6;   // column fraction bits

    localparam logic [ZW-1:0] Z_FAR          = 16'hFFFF;
    localparam logic [15:0]   SPECKLE_THR_RST = 16'd101;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_PIXEL = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [2:0] OC_SPLAT   = 3'd0;
    localparam logic [2:0] OC_BAD_IDX = 3'd1;
    localparam logic [2:0] OC_ZERO    = 3'd2;
    localparam logic [2:0] OC_SPECKLE = 3'd3;
    localparam logic [2:0] OC_NO_LINE = 3'd4;

    localparam logic [1:0] REG_MIRROR  = 2'd0;
    localparam logic [1:0] REG_SPECKLE = 2'd1;
    localparam logic [1:0] REG_SCALE   = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

### hdl/dcr_ram.sv
// single port synchronous ram with registered read data
// depends on nothing but its parameters
module dcr_ram #(
    parameter int DEPTH = 256,
    parameter int DW    = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### hdl/dcr_div.sv
// serial restoring divider, one quotient bit per cycle
// uses dcr_pkg for widths and the status struct
module dcr_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [dcr_pkg::NUM_W-1:0] dividend,
    input  logic [dcr_pkg::ZW-1:0]    divisor,
    output logic [dcr_pkg::NUM_W-1:0] quotient,
    output dcr_pkg::div_sts_t         sts
);

    localparam int CW = $clog2(dcr_pkg::NUM_W + 1);

    logic [dcr_pkg::NUM_W-1:0] dq_reg, dq_next;
    logic [dcr_pkg::ZW-1:0]    rem_reg, rem_next;
    logic [dcr_pkg::ZW-1:0]    dvs_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      busy_reg, done_reg;
    logic [dcr_pkg::ZW:0]      trial;
    logic [dcr_pkg::ZW:0]      diff;

    always_comb
    begin
        trial = {rem_reg, dq_reg[dcr_pkg::NUM_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (!diff[dcr_pkg::ZW])
        begin
            rem_next = diff[dcr_pkg::ZW-1:0];
            dq_next  = {dq_reg[dcr_pkg::NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[dcr_pkg::ZW-1:0];
            dq_next  = {dq_reg[dcr_pkg::NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(dcr_pkg::NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = dq_reg;
    assign sts      = '{busy: busy_reg, done: done_reg};

endmodule

### hdl/depth_to_color_registration.sv
// top level: control sequencer around the raw and output depth memories
// uses dcr_pkg, dcr_ram and dcr_div
// One request is worked at a time and every request gives one result. A raw load goes
// straight to ST_DONE, an output read through ST_READ. A frame start clears the output
// memory one entry per cycle; the same clearing pass runs after reset, with no request
// taken meanwhile. A pixel registration makes three raw reads on the single raw port, a
// 35 step serial column divide that holds the sequencer and six read-modify-write updates
// on the single output port; rejected pixels skip the divide and the updates. A result
// waits in ST_DONE while the previous one has not been taken by m_tready.
// A result waiting in the output register does not stop the next request being taken.
module depth_to_color_registration #(
    parameter int DEPTH_WIDTH  = dcr_pkg::DEPTH_WIDTH_DEF,
    parameter int DEPTH_PIXELS = dcr_pkg::DEPTH_PIXELS_DEF,
    parameter int OUT_WIDTH    = dcr_pkg::OUT_WIDTH_DEF,
    parameter int OUT_PIXELS   = dcr_pkg::OUT_PIXELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address, depth_value, raw_index, column_base, line_offset, zero fill
    input  logic [95:0] s_tdata,
    // op
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_depth, outcome, zero fill
    output logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int RAW_AW = $clog2(DEPTH_PIXELS);
    localparam int OUT_AW = $clog2(OUT_PIXELS);
    localparam int MIRROR_BASE = OUT_PIXELS - OUT_WIDTH - 3;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RAWZ, ST_RIGHT, ST_BELOW, ST_DIV,
        ST_IDX, ST_PRD, ST_PWR, ST_READ, ST_DONE
    } state_t;

    state_t state_reg;

    // request fields
    logic [1:0]         op;
    logic [18:0]        address;
    logic [15:0]        depth_value;
    logic signed [18:0] raw_index;
    logic signed [16:0] column_base;
    logic signed [19:0] line_offset;

    assign op          = s_tuser;
    assign address     = s_tdata[18:0];
    assign depth_value = s_tdata[34:19];
    assign raw_index   = s_tdata[53:35];
    assign column_base = s_tdata[70:54];
    assign line_offset = s_tdata[90:71];

    // configuration
    logic        mirror_reg;
    logic [15:0] thr_reg;
    logic [31:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg <= 1'b0;
            thr_reg    <= dcr_pkg::SPECKLE_THR_RST;
            scale_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dcr_pkg::REG_MIRROR:  mirror_reg <= cfg_data[0];
                dcr_pkg::REG_SPECKLE: thr_reg    <= cfg_data[15:0];
                dcr_pkg::REG_SCALE:   scale_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // working registers
    logic [RAW_AW-1:0]                 raw_reg;
    logic [15:0]                       z_reg;
    logic signed [16:0]                base_reg;
    logic signed [19:0]                line_reg;
    logic signed [33:0]                prod_reg;
    logic signed [dcr_pkg::NUM_W-1:0]  num_reg;
    logic                              neg_reg;
    logic                              right_ok_reg;
    logic signed [dcr_pkg::IDX_W-1:0]  idx_reg;
    logic [2:0]                        k_reg;
    logic                              inr_reg;
    logic                              rd_ok_reg;
    logic                              clr_item_reg;
    logic [OUT_AW-1:0]                 clr_cnt_reg;
    logic [15:0]                       rd_res_reg;
    logic [2:0]                        oc_res_reg;
    logic                              m_tvalid_reg;
    logic [23:0]                       m_tdata_reg;

    // memories
    logic              raw_we;
    logic [RAW_AW-1:0] raw_addr;
    logic [15:0]       raw_rdata;
    logic              out_we;
    logic [OUT_AW-1:0] out_addr;
    logic [15:0]       out_wdata;
    logic [15:0]       out_rdata;

    dcr_ram #(.DEPTH(DEPTH_PIXELS), .DW(dcr_pkg::ZW)) u_raw_mem (
        .clk  (clk),
        .we   (raw_we),
        .addr (raw_addr),
        .wdata(depth_value),
        .rdata(raw_rdata)
    );

    dcr_ram #(.DEPTH(OUT_PIXELS), .DW(dcr_pkg::ZW)) u_out_mem (
        .clk  (clk),
        .we   (out_we),
        .addr (out_addr),
        .wdata(out_wdata),
        .rdata(out_rdata)
    );

    // divider
    logic                            div_start;
    logic [dcr_pkg::NUM_W-1:0]       div_dividend;
    logic [dcr_pkg::NUM_W-1:0]       div_q;
    dcr_pkg::div_sts_t               div_sts;

    dcr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (z_reg),
        .quotient(div_q),
        .sts     (div_sts)
    );

    logic accept;
    logic raw_bad;
    logic load_ok;
    logic read_ok;
    logic right_exist, below_exist;
    logic [16:0] d_right, d_below;
    logic right_sim, below_sim;
    logic below_ok;
    logic signed [dcr_pkg::IDX_W-1:0] col;
    logic [dcr_pkg::IDX_W-1:0]        off;
    logic signed [dcr_pkg::IDX_W-1:0] pa;
    logic                             pa_inr;
    logic                             div_go;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        raw_bad = raw_index[18] || (32'(raw_index[17:0]) >= DEPTH_PIXELS);
        load_ok = 32'(address) < DEPTH_PIXELS;
        read_ok = 32'(address) < OUT_PIXELS;

        right_exist = 32'(raw_reg) < DEPTH_PIXELS - 1;
        below_exist = 32'(raw_reg) < DEPTH_PIXELS - DEPTH_WIDTH;
        d_right = (z_reg > raw_rdata) ? 17'(z_reg) - 17'(raw_rdata)
                                      : 17'(raw_rdata) - 17'(z_reg);
        d_below = d_right;
        right_sim = (d_right <= 17'(thr_reg));
        below_sim = (d_below <= 17'(thr_reg));
        below_ok  = below_exist && below_sim;
        div_go    = (state_reg == ST_BELOW) && (right_ok_reg || below_ok)
                    && !line_reg[19];

        div_dividend = num_reg[dcr_pkg::NUM_W-1] ? dcr_pkg::NUM_W'(-num_reg)
                                                 : dcr_pkg::NUM_W'(num_reg);
        div_start = div_go;

        col = neg_reg ? -dcr_pkg::IDX_W'(div_q >> dcr_pkg::Q_SHIFT)
                      :  dcr_pkg::IDX_W'(div_q >> dcr_pkg::Q_SHIFT);

        // patch columns 0..2 on the line, then 0..2 on the next line
        off = (k_reg < 3'd3) ? dcr_pkg::IDX_W'(k_reg)
                             : dcr_pkg::IDX_W'(OUT_WIDTH) + dcr_pkg::IDX_W'(k_reg - 3'd3);
        pa     = idx_reg + signed'(off);
        pa_inr = !pa[dcr_pkg::IDX_W-1] && (pa < dcr_pkg::IDX_W'(OUT_PIXELS));
    end

    // memory port steering
    always_comb
    begin
        raw_we    = 1'b0;
        raw_addr  = RAW_AW'(address);
        out_we    = 1'b0;
        out_addr  = OUT_AW'(address);
        out_wdata = z_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (op == dcr_pkg::OP_LOAD)
                begin
                    raw_we = accept && load_ok;
                end
                else if (op == dcr_pkg::OP_PIXEL)
                begin
                    raw_addr = RAW_AW'(raw_index[17:0]);
                end
            end
            ST_RAWZ:  raw_addr = raw_reg + RAW_AW'(1);
            ST_RIGHT: raw_addr = raw_reg + RAW_AW'(DEPTH_WIDTH);
            ST_CLEAR:
            begin
                out_we    = 1'b1;
                out_addr  = clr_cnt_reg;
                out_wdata = dcr_pkg::Z_FAR;
            end
            ST_PRD: out_addr = OUT_AW'(pa);
            ST_PWR:
            begin
                out_addr = OUT_AW'(pa);
                out_we   = inr_reg && (z_reg < out_rdata);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            clr_item_reg <= 1'b0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_cnt_reg == OUT_AW'(OUT_PIXELS - 1))
                    begin
                        clr_cnt_reg <= '0;
                        state_reg   <= clr_item_reg ? ST_DONE : ST_IDLE;
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        rd_res_reg   <= '0;
                        oc_res_reg   <= (op == dcr_pkg::OP_PIXEL && raw_bad)
                                        ? dcr_pkg::OC_BAD_IDX : dcr_pkg::OC_SPLAT;
                        raw_reg      <= RAW_AW'(raw_index[17:0]);
                        base_reg     <= column_base;
                        line_reg     <= line_offset;
                        rd_ok_reg    <= read_ok;
                        clr_item_reg <= 1'b1;
                        case (op)
                            dcr_pkg::OP_CLEAR: state_reg <= ST_CLEAR;
                            dcr_pkg::OP_LOAD:  state_reg <= ST_DONE;
                            dcr_pkg::OP_READ:  state_reg <= ST_READ;
                            dcr_pkg::OP_PIXEL:
                            begin
                                if (raw_bad)
                                begin
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    state_reg <= ST_RAWZ;
                                end
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_RAWZ:
                begin
                    z_reg    <= raw_rdata;
                    prod_reg <= base_reg * signed'({1'b0, raw_rdata});
                    if (raw_rdata == '0)
                    begin
                        oc_res_reg <= dcr_pkg::OC_ZERO;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_RIGHT;
                    end
                end
                ST_RIGHT:
                begin
                    right_ok_reg <= right_exist && right_sim;
                    num_reg <= dcr_pkg::NUM_W'(prod_reg)
                               - signed'({3'b000, scale_reg});
                    state_reg <= ST_BELOW;
                end
                ST_BELOW:
                begin
                    neg_reg <= num_reg[dcr_pkg::NUM_W-1];
                    if (!right_ok_reg && !below_ok)
                    begin
                        oc_res_reg <= dcr_pkg::OC_SPECKLE;
                        state_reg  <= ST_DONE;
                    end
                    else if (line_reg[19])
                    begin
                        oc_res_reg <= dcr_pkg::OC_NO_LINE;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_sts.done)
                    begin
                        idx_reg   <= dcr_pkg::IDX_W'(line_reg) + col;
                        state_reg <= ST_IDX;
                    end
                end
                ST_IDX:
                begin
                    if (mirror_reg)
                    begin
                        idx_reg <= dcr_pkg::IDX_W'(MIRROR_BASE) - idx_reg;
                    end
                    k_reg     <= '0;
                    state_reg <= ST_PRD;
                end
                ST_PRD:
                begin
                    inr_reg   <= pa_inr;
                    state_reg <= ST_PWR;
                end
                ST_PWR:
                begin
                    k_reg <= k_reg + 1'b1;
                    state_reg <= (k_reg == 3'd5) ? ST_DONE : ST_PRD;
                end
                ST_READ:
                begin
                    rd_res_reg <= rd_ok_reg ? out_rdata : '0;
                    state_reg  <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'b00000, oc_res_reg, rd_res_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // raw memory is written only by an accepted load request
    a_raw_write: assert property (@(posedge clk) disable iff (!rst_n)
        raw_we |-> (accept && op == dcr_pkg::OP_LOAD))
        else $error("raw store written outside a load request");

    // a patch update only ever lowers the stored depth
    a_min_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_we && state_reg == ST_PWR) |-> (out_wdata < out_rdata))
        else $error("patch update does not lower depth");

    // the divider finishes only while the sequencer waits on it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    // a new result is loaded only when the previous one is gone
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready) |=> m_tvalid_reg)
        else $error("pending result lost");

endmodule

### tb/sv/tb_depth_to_color_registration.sv
// testbench for depth_to_color_registration: directed and random requests checked
// against an in-bench z-buffer splat predictor; depends on dcr_pkg and the rtl top
module tb_depth_to_color_registration;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW  = dcr_pkg::DEPTH_WIDTH_DEF;
    localparam int DP  = dcr_pkg::DEPTH_PIXELS_DEF;
    localparam int OW  = dcr_pkg::OUT_WIDTH_DEF;
    localparam int OP  = dcr_pkg::OUT_PIXELS_DEF;
    localparam int TOTAL_ITEMS = 1550;
    localparam int SETTLE = 80;

    typedef struct {
        logic [1:0]         op;
        logic [18:0]        addr;
        logic [15:0]        depth;
        logic signed [18:0] raw;
        logic signed [16:0] base;
        logic signed [19:0] line;
    } request_t;

    typedef struct {
        logic [15:0] read_depth;
        logic [2:0]  outcome;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // predictor copy of the block state
    logic [15:0] raw_mem [DP];
    bit          raw_seen [DP];
    logic [15:0] out_mem [OP];
    bit          mirror_on;
    logic [15:0] speckle_thr;
    logic [31:0] disp_scale;
    longint      last_patch;

    result_t     pending_results[$];
    int          errors;
    int          sent;
    bit          no_idle;

    depth_to_color_registration u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit near(input logic [15:0] z, input longint idx);
        logic [16:0] d;
        d = (z > raw_mem[idx]) ? 17'(z) - 17'(raw_mem[idx]) : 17'(raw_mem[idx]) - 17'(z);
        return d <= speckle_thr;
    endfunction

    function automatic void splat(input longint idx, input logic [15:0] z);
        if (idx >= 0 && idx < OP && z < out_mem[idx])
            out_mem[idx] = z;
    endfunction

    function automatic logic [2:0] register_outcome(input request_t r);
        longint     ri, num, den, col, idx;
        logic [15:0] z;
        bit         right_ok, below_ok;
        ri = r.raw;
        if (ri < 0 || ri >= DP)
            return dcr_pkg::OC_BAD_IDX;
        z = raw_mem[ri];
        if (z == 0)
            return dcr_pkg::OC_ZERO;
        right_ok = (ri < DP - 1) && near(z, ri + 1);
        below_ok = (ri < DP - DW) && near(z, ri + DW);
        if (!right_ok && !below_ok)
            return dcr_pkg::OC_SPECKLE;
        if (r.line < 0)
            return dcr_pkg::OC_NO_LINE;
        num = longint'(r.base) * longint'(z) - longint'(disp_scale);
        den = longint'(z) * 64;
        col = num / den;
        idx = longint'(r.line) + col;
        if (mirror_on)
            idx = (OP - OW - 3) - idx;
        last_patch = idx;
        for (int k = 0; k < 3; k++)
        begin
            splat(idx + k, z);
            splat(idx + OW + k, z);
        end
        return dcr_pkg::OC_SPLAT;
    endfunction

    function automatic result_t predict_result(input request_t r);
        result_t res;
        res.read_depth = '0;
        res.outcome = dcr_pkg::OC_SPLAT;
        case (r.op)
            dcr_pkg::OP_CLEAR: foreach (out_mem[i]) out_mem[i] = dcr_pkg::Z_FAR;
            dcr_pkg::OP_LOAD:
                if (r.addr < DP)
                begin
                    raw_mem[r.addr] = r.depth;
                    raw_seen[r.addr] = 1'b1;
                end
            dcr_pkg::OP_PIXEL: res.outcome = register_outcome(r);
            default:
                if (r.addr < OP)
                    res.read_depth = out_mem[r.addr];
        endcase
        return res;
    endfunction

    // a pixel request is legal only when every raw entry it reads has been written
    function automatic bit pixel_ready(input longint ri);
        if (ri < 0 || ri >= DP)
            return 1'b1;
        if (!raw_seen[ri])
            return 1'b0;
        if (ri < DP - 1 && !raw_seen[ri + 1])
            return 1'b0;
        if (ri < DP - DW && !raw_seen[ri + DW])
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_request(input logic [1:0] op, input int addr, input int depth,
                                input int raw, input int base, input int line);
        request_t r;
        r.op = op;
        r.addr = addr[18:0];
        r.depth = depth[15:0];
        r.raw = raw[18:0];
        r.base = base[16:0];
        r.line = line[19:0];
        // illegal pixels become an out-of-range index
        if (op == dcr_pkg::OP_PIXEL && !pixel_ready(r.raw))
            r.raw = 19'(DP + $urandom_range(0, 262143 - DP));
        s_tvalid = 1'b1;
        s_tuser = r.op;
        s_tdata = {5'd0, r.line, r.base, r.raw, r.depth, r.addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_result(r));
        sent++;
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 99) < 14)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            dcr_pkg::REG_MIRROR:  mirror_on = value[0];
            dcr_pkg::REG_SPECKLE: speckle_thr = value[15:0];
            default:              disp_scale = value;
        endcase
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.read_depth)
                    report_mismatch($sformatf("read_depth %h, expected %h",
                                              m_tdata[15:0], want.read_depth));
                if (m_tdata[18:16] !== want.outcome)
                    report_mismatch($sformatf("outcome %0d, expected %0d",
                                              m_tdata[18:16], want.outcome));
            end
        end
    end

    always @(negedge clk)
        m_tready <= no_idle || ($urandom_range(0, 99) >= 14);

    task automatic test_directed_cases();
        send_request(dcr_pkg::OP_READ, 0, 0, 0, 0, 0);
        send_request(dcr_pkg::OP_LOAD, 0, 1000, 0, 0, 0);
        send_request(dcr_pkg::OP_LOAD, 1, 1000, 0, 0, 0);
        send_request(dcr_pkg::OP_LOAD, DW, 1101, 0, 0, 0);
        send_request(dcr_pkg::OP_LOAD, 100, 0, 0, 0, 0);
        send_request(dcr_pkg::OP_LOAD, 101, 5, 0, 0, 0);
        send_request(dcr_pkg::OP_LOAD, 100 + DW, 5, 0, 0, 0);
        send_request(dcr_pkg::OP_LOAD, DP - 1, 16'hFFFF, 0, 0, 0);
        send_request(dcr_pkg::OP_LOAD, 19'h7FFFF, 16'hFFFF, 0, 0, 0);
        send_request(dcr_pkg::OP_PIXEL, 0, 0, -1, 0, 0);
        send_request(dcr_pkg::OP_PIXEL, 0, 0, DP, 0, 0);
        send_request(dcr_pkg::OP_PIXEL, 0, 0, 100, 0, 0);
        send_request(dcr_pkg::OP_PIXEL, 0, 0, DP - 1, 0, 0);
        send_request(dcr_pkg::OP_PIXEL, 0, 0, 0, 0, -1);
        send_request(dcr_pkg::OP_PIXEL, 0, 0, 0, -65536, 0);
        send_request(dcr_pkg::OP_PIXEL, 0, 0, 0, 65535, 517440);
        send_request(dcr_pkg::OP_READ, 0, 0, 0, 0, 0);
        send_request(dcr_pkg::OP_READ, 2, 0, 0, 0, 0);
        send_request(dcr_pkg::OP_READ, OW + 1, 0, 0, 0, 0);
        send_request(dcr_pkg::OP_READ, OP - 1, 0, 0, 0, 0);
        send_request(dcr_pkg::OP_READ, 19'h7FFFF, 0, 0, 0, 0);
        send_request(dcr_pkg::OP_CLEAR, 19'h7FFFF, 16'hFFFF, -1, -1, -1);
        send_request(dcr_pkg::OP_READ, 1, 0, 0, 0, 0);
    endtask

    task automatic splat_sequence();
        int r, z, zr, zb, spread, base, line;
        case ($urandom_range(0, 7))
            0: r = DP - 1 - $urandom_range(0, 2);
            1: r = DP - DW - 1 + $urandom_range(0, 2);
            default: r = $urandom_range(0, DP - 1);
        endcase
        z = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 65535);
        if ($urandom_range(0, 2) == 0)
            z = $urandom_range(1, 64);
        spread = $urandom_range(0, 1) ? int'(speckle_thr) + 2 : 300;
        zr = z + $urandom_range(0, 2 * spread) - spread;
        zb = z + $urandom_range(0, 2 * spread) - spread;
        if ($urandom_range(0, 9) == 0)
            zr = $urandom_range(0, 65535);
        zr = (zr < 0) ? 0 : (zr > 65535) ? 65535 : zr;
        zb = (zb < 0) ? 0 : (zb > 65535) ? 65535 : zb;
        send_request(dcr_pkg::OP_LOAD, r, z, 0, 0, 0);
        if (r < DP - 1)
            send_request(dcr_pkg::OP_LOAD, r + 1, zr, 0, 0, 0);
        if (r < DP - DW)
            send_request(dcr_pkg::OP_LOAD, r + DW, zb, 0, 0, 0);
        base = $urandom_range(0, 131071) - 65536;
        line = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1048575) - 524288
                                           : $urandom_range(0, 517440);
        last_patch = -1;
        send_request(dcr_pkg::OP_PIXEL, 0, 0, r, base, line);
        repeat ($urandom_range(1, 3))
        begin
            if (last_patch >= 0 && last_patch < OP)
                send_request(dcr_pkg::OP_READ, int'(last_patch) + $urandom_range(0, 3)
                             + ($urandom_range(0, 1) ? OW : 0), 0, 0, 0, 0);
            else
                send_request(dcr_pkg::OP_READ, $urandom_range(0, OP - 1), 0, 0, 0, 0);
        end
    endtask

    task automatic noise_request();
        int a;
        a = $urandom_range(0, 19'h7FFFF);
        case ($urandom_range(0, 2))
            0: send_request(dcr_pkg::OP_LOAD, a, $urandom_range(0, 65535), 0, 0, 0);
            1: send_request(dcr_pkg::OP_READ, a, 0, 0, 0, 0);
            default: send_request(dcr_pkg::OP_PIXEL, a, $urandom,
                                  $urandom_range(0, 19'h7FFFF), $urandom, $urandom);
        endcase
    endtask

    task automatic test_random_phase(input bit mir, input logic [15:0] thr,
                                     input logic [31:0] scale, input int stop_at);
        drain();
        write_register(dcr_pkg::REG_MIRROR, {31'd0, mir});
        write_register(dcr_pkg::REG_SPECKLE, {16'd0, thr});
        write_register(dcr_pkg::REG_SCALE, scale);
        while (sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 6)
                splat_sequence();
            else
                noise_request();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = dcr_pkg::OP_CLEAR;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = dcr_pkg::REG_MIRROR;
        cfg_data = '0;
        errors = 0;
        sent = 0;
        no_idle = 1'b0;
        mirror_on = 1'b0;
        speckle_thr = dcr_pkg::SPECKLE_THR_RST;
        disp_scale = '0;
        foreach (out_mem[i]) out_mem[i] = dcr_pkg::Z_FAR;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_random_phase(1'b1, 16'd0, 32'hFFFF_FFFF, 330);
        no_idle = 1'b1;
        test_random_phase(1'b0, 16'hFFFF, $urandom_range(0, 1 << 22), 640);
        no_idle = 1'b0;
        test_random_phase(1'b1, 16'($urandom_range(0, 400)), $urandom_range(0, 1 << 24), 950);
        test_random_phase(1'b0, 16'd101, 32'd0, 1250);
        test_random_phase(1'b0, 16'($urandom), $urandom, TOTAL_ITEMS);

        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### files.f
hdl/dcr_pkg.sv
hdl/dcr_ram.sv
hdl/dcr_div.sv
hdl/depth_to_color_registration.sv
tb/sv/tb_depth_to_color_registration.sv
